// ===== hdl/sba_pkg.sv =====
// Package for the size-class buffer allocator: widths, codes and record types.
// No dependencies; every other file uses it.
package sba_pkg;

    localparam int NUM_BANKS        = 4;
    localparam int BUFFERS_PER_BANK = 256;
    localparam int BANK_W           = 2;
    localparam int ID_W             = 8;
    localparam int ADDR_W           = BANK_W + ID_W;
    localparam int DEPTH            = NUM_BANKS * BUFFERS_PER_BANK;
    localparam int CNT_W            = 9;
    localparam int TAG_W            = 32;
    localparam int SIZE_W           = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int RING_W           = ID_W + 1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_BY_SIZE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_OWNED    = 2'd2;
    localparam logic [1:0] ST_UNOWNED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT0 = 3'd4;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BANK_W-1:0] bank_sel;
        logic [ID_W-1:0]   buffer_index;
        logic [TAG_W-1:0]  owner_tag;
        logic [SIZE_W-1:0] wanted_size;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BANK_W-1:0] granted_bank;
        logic [ID_W-1:0]   granted_buffer;
        logic [CNT_W-1:0]  in_use_count;
    } rsp_t;

    // Memory port bundle from the sequencer to the state store.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] ring_raddr;
        logic [ADDR_W-1:0] own_raddr;
        logic              ring_we;
        logic [ADDR_W-1:0] ring_waddr;
        logic [RING_W-1:0] ring_wdata;
        logic              own_we;
        logic [ADDR_W-1:0] own_waddr;
        logic [TAG_W-1:0]  own_wdata;
    } mem_cmd_t;

endpackage

// ===== hdl/sba_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Depends on sba_pkg for the payload types.
interface sba_req_if;
    logic            valid;
    logic            ready;
    sba_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sba_rsp_if;
    logic            valid;
    logic            ready;
    sba_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sba_store.sv =====
// Ring and owner memories with registered reads, plus the bank clearing pass.
// Depends on sba_pkg. A bank being cleared is rewritten to its reset contents entry by entry.
module sba_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sba_pkg::mem_cmd_t                   cmd,
    input  logic [sba_pkg::NUM_BANKS-1:0]       bank_clear,
    output logic                                clr_busy,
    output logic [sba_pkg::RING_W-1:0]          ring_rdata,
    output logic [sba_pkg::TAG_W-1:0]           own_rdata
);
    import sba_pkg::*;

    logic [RING_W-1:0]    ring_mem [DEPTH];
    logic [TAG_W-1:0]     own_mem  [DEPTH];
    logic [NUM_BANKS-1:0] pend_reg, pend_next;
    logic [NUM_BANKS-1:0] pick;
    logic                 clr_run_reg, clr_run_next;
    logic [BANK_W-1:0]    clr_bank_reg, clr_bank_next;
    logic [ID_W-1:0]      clr_id_reg, clr_id_next;
    logic [ADDR_W-1:0]    clr_addr;

    // Lowest bank that still waits for its clearing pass.
    assign pick     = pend_reg & (~pend_reg + 1'b1);
    assign clr_addr = {clr_bank_reg, clr_id_reg};
    assign clr_busy = clr_run_reg || (pend_reg != '0);

    // Clearing pass: one entry per cycle, one bank at a time.
    always_comb
    begin
        pend_next     = pend_reg | bank_clear;
        clr_run_next  = clr_run_reg;
        clr_bank_next = clr_bank_reg;
        clr_id_next   = clr_id_reg;
        if (clr_run_reg)
        begin
            clr_id_next = clr_id_reg + 1'b1;
            if (clr_id_reg == '1)
            begin
                clr_run_next = 1'b0;
            end
        end
        else if (pend_reg != '0)
        begin
            clr_run_next = 1'b1;
            clr_id_next  = '0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                if (pick[b])
                begin
                    clr_bank_next = BANK_W'(b);
                end
            end
            pend_next = (pend_reg & ~pick) | bank_clear;
        end
    end

    // All banks are queued for clearing after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '1;
            clr_run_reg  <= 1'b0;
            clr_bank_reg <= '0;
            clr_id_reg   <= '0;
        end
        else
        begin
            pend_reg     <= pend_next;
            clr_run_reg  <= clr_run_next;
            clr_bank_reg <= clr_bank_next;
            clr_id_reg   <= clr_id_next;
        end
    end

    // Memory writes and registered reads; the clearing pass has the write port first.
    always_ff @(posedge clk)
    begin
        if (clr_run_reg)
        begin
            ring_mem[clr_addr] <= {1'b1, clr_id_reg};
            own_mem[clr_addr]  <= '0;
        end
        else
        begin
            if (cmd.ring_we)
            begin
                ring_mem[cmd.ring_waddr] <= cmd.ring_wdata;
            end
            if (cmd.own_we)
            begin
                own_mem[cmd.own_waddr] <= cmd.own_wdata;
            end
        end
        if (cmd.rd_en)
        begin
            ring_rdata <= ring_mem[cmd.ring_raddr];
            own_rdata  <= own_mem[cmd.own_raddr];
        end
    end

endmodule

// ===== hdl/sba_ctrl.sv =====
// Request sequencer: cursors, counts, configuration and read-modify-write steps.
// Depends on sba_pkg and the interfaces in sba_if.sv.
module sba_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    sba_req_if.sink                           req,
    sba_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sba_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sba_pkg::mem_cmd_t                 cmd,
    output logic [sba_pkg::NUM_BANKS-1:0]     bank_clear,
    input  logic                              clr_busy,
    input  logic [sba_pkg::RING_W-1:0]        ring_rdata,
    input  logic [sba_pkg::TAG_W-1:0]         own_rdata
);
    import sba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_OWNER = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [BANK_W-1:0]   bank_reg, bank_next;
    logic                owned_seen_reg, owned_seen_next;
    logic [ID_W-1:0]     bid_reg, bid_next;
    logic [SIZE_W-1:0]   size_reg [NUM_BANKS];
    logic [CNT_W-1:0]    count_reg [NUM_BANKS];
    logic [ID_W-1:0]     acur_reg [NUM_BANKS];
    logic [ID_W-1:0]     rcur_reg [NUM_BANKS];
    logic [CNT_W-1:0]    used_reg [NUM_BANKS];
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_load;
    logic                acur_step, rcur_step, used_inc, used_dec;
    logic [BANK_W-1:0]   upd_bank;
    logic [BANK_W-1:0]   cand_bank;
    logic                cand_found;
    logic [CNT_W-1:0]    eff_count;
    logic [ID_W-1:0]     next_acur, next_rcur;

    // First fitting bank at or above the start bank, for allocate by size.
    function automatic logic [BANK_W:0] first_fit(
        input logic [BANK_W-1:0] start, input logic [SIZE_W-1:0] want,
        input logic [SIZE_W*NUM_BANKS-1:0] sizes);
        logic [BANK_W:0] res;
        res = '0;
        for (int b = NUM_BANKS - 1; b >= 0; b--)
        begin
            if (b >= int'(start) && sizes[b*SIZE_W +: SIZE_W] >= want)
            begin
                res = {1'b1, BANK_W'(b)};
            end
        end
        return res;
    endfunction

    logic [SIZE_W*NUM_BANKS-1:0] sizes_flat;
    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            sizes_flat[b*SIZE_W +: SIZE_W] = size_reg[b];
        end
    end

    logic [BANK_W:0] fit_start, fit_next;
    assign fit_start = first_fit('0, req.data.wanted_size, sizes_flat);
    assign fit_next  = (bank_reg == BANK_W'(NUM_BANKS - 1)) ? '0 :
                       first_fit(bank_reg + 1'b1, req_reg.wanted_size, sizes_flat);

    assign cand_bank  = fit_next[BANK_W-1:0];
    assign cand_found = fit_next[BANK_W];

    // Effective wrap point of the bank being updated, clamped to 1..BUFFERS_PER_BANK.
    always_comb
    begin
        eff_count = count_reg[upd_bank];
        if (eff_count == '0)
        begin
            eff_count = CNT_W'(1);
        end
        if (eff_count > CNT_W'(BUFFERS_PER_BANK))
        begin
            eff_count = CNT_W'(BUFFERS_PER_BANK);
        end
    end
    assign next_acur = ({1'b0, acur_reg[upd_bank]} + 1'b1 >= eff_count) ? '0
                       : acur_reg[upd_bank] + 1'b1;
    assign next_rcur = ({1'b0, rcur_reg[upd_bank]} + 1'b1 >= eff_count) ? '0
                       : rcur_reg[upd_bank] + 1'b1;

    // No request is taken while a bank is being cleared.
    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg && !clr_busy;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Sequencer: read ring slot, then owner of the id, then write back; a release reads the owner only.
    always_comb
    begin
        state_t st;
        st              = state_reg;
        bank_next       = bank_reg;
        owned_seen_next = owned_seen_reg;
        bid_next        = bid_reg;
        rsp_next        = rsp_reg;
        rsp_load        = 1'b0;
        cmd             = '0;
        acur_step       = 1'b0;
        rcur_step       = 1'b0;
        used_inc        = 1'b0;
        used_dec        = 1'b0;
        upd_bank        = bank_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    owned_seen_next = 1'b0;
                    bank_next       = req.data.bank_sel;
                    case (req.data.operation)
                        OP_ALLOC:
                        begin
                            if (req.data.owner_tag == '0)
                            begin
                                rsp_next = '{ST_NO_FREE, '0, '0, used_reg[req.data.bank_sel]};
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_en      = 1'b1;
                                cmd.ring_raddr = {req.data.bank_sel,
                                                  acur_reg[req.data.bank_sel]};
                                st = S_READ;
                            end
                        end
                        OP_BY_SIZE:
                        begin
                            if (req.data.owner_tag == '0 || !fit_start[BANK_W])
                            begin
                                rsp_next = '{ST_NO_FREE, '0, '0, used_reg[req.data.bank_sel]};
                                rsp_load = 1'b1;
                            end
                            else
                            begin
                                bank_next      = fit_start[BANK_W-1:0];
                                cmd.rd_en      = 1'b1;
                                cmd.ring_raddr = {fit_start[BANK_W-1:0],
                                                  acur_reg[fit_start[BANK_W-1:0]]};
                                st = S_READ;
                            end
                        end
                        OP_RELEASE:
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.own_raddr = {req.data.bank_sel, req.data.buffer_index};
                            bid_next      = req.data.buffer_index;
                            st = S_OWNER;
                        end
                        default:
                        begin
                            rsp_next = '{ST_OK, '0, '0, used_reg[req.data.bank_sel]};
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Ring slot is here; fetch the owner of the id it names.
                if (!ring_rdata[ID_W])
                begin
                    st = S_DONE;
                end
                else
                begin
                    bid_next      = ring_rdata[ID_W-1:0];
                    cmd.rd_en     = 1'b1;
                    cmd.own_raddr = {bank_reg, ring_rdata[ID_W-1:0]};
                    st = S_OWNER;
                end
            end
            S_OWNER:
            begin
                if (req_reg.operation == OP_RELEASE)
                begin
                    if (own_rdata == '0)
                    begin
                        rsp_next = '{ST_UNOWNED, '0, '0, used_reg[bank_reg]};
                    end
                    else
                    begin
                        cmd.own_we     = 1'b1;
                        cmd.own_waddr  = {bank_reg, bid_reg};
                        cmd.own_wdata  = '0;
                        cmd.ring_we    = 1'b1;
                        cmd.ring_waddr = {bank_reg, rcur_reg[bank_reg]};
                        cmd.ring_wdata = {1'b1, bid_reg};
                        rcur_step      = 1'b1;
                        used_dec       = used_reg[bank_reg] != '0;
                        rsp_next = '{ST_OK, '0, '0, used_reg[bank_reg] - CNT_W'(used_dec)};
                    end
                    rsp_load = 1'b1;
                    st = S_IDLE;
                end
                else if (own_rdata != '0)
                begin
                    owned_seen_next = 1'b1;
                    st = S_DONE;
                end
                else
                begin
                    cmd.own_we     = 1'b1;
                    cmd.own_waddr  = {bank_reg, bid_reg};
                    cmd.own_wdata  = req_reg.owner_tag;
                    cmd.ring_we    = 1'b1;
                    cmd.ring_waddr = {bank_reg, acur_reg[bank_reg]};
                    cmd.ring_wdata = '0;
                    acur_step      = 1'b1;
                    used_inc       = used_reg[bank_reg] < CNT_W'(BUFFERS_PER_BANK);
                    rsp_next = '{ST_OK, bank_reg, bid_reg,
                                 used_reg[bank_reg] + CNT_W'(used_inc)};
                    rsp_load = 1'b1;
                    st = S_IDLE;
                end
            end
            S_DONE:
            begin
                // This bank failed; by-size moves on to the next fitting bank.
                if (req_reg.operation == OP_BY_SIZE && cand_found)
                begin
                    bank_next      = cand_bank;
                    cmd.rd_en      = 1'b1;
                    cmd.ring_raddr = {cand_bank, acur_reg[cand_bank]};
                    st = S_READ;
                end
                else
                begin
                    rsp_next = '{(owned_seen_reg ? ST_OWNED : ST_NO_FREE), '0, '0,
                                 used_reg[req_reg.bank_sel]};
                    rsp_load = 1'b1;
                    st = S_IDLE;
                end
            end
            default:
            begin
                st = S_IDLE;
            end
        endcase
        state_next = st;
    end

    // Control registers, cursors, counts and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            bank_reg       <= '0;
            owned_seen_reg <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                size_reg[b]  <= SIZE_W'(64 << (2 * b));
                count_reg[b] <= CNT_W'(BUFFERS_PER_BANK);
                acur_reg[b]  <= '0;
                rcur_reg[b]  <= '0;
                used_reg[b]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            owned_seen_reg <= owned_seen_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (acur_step)
            begin
                acur_reg[upd_bank] <= next_acur;
            end
            if (rcur_step)
            begin
                rcur_reg[upd_bank] <= next_rcur;
            end
            if (used_inc)
            begin
                used_reg[upd_bank] <= used_reg[upd_bank] + 1'b1;
            end
            if (used_dec)
            begin
                used_reg[upd_bank] <= used_reg[upd_bank] - 1'b1;
            end
            if (cfg_we)
            begin
                if (cfg_index < REG_COUNT0)
                begin
                    size_reg[cfg_index[BANK_W-1:0]] <= cfg_data;
                end
                else
                begin
                    count_reg[cfg_index[BANK_W-1:0]] <= cfg_data[CNT_W-1:0];
                    acur_reg[cfg_index[BANK_W-1:0]]  <= '0;
                    rcur_reg[cfg_index[BANK_W-1:0]]  <= '0;
                    used_reg[cfg_index[BANK_W-1:0]]  <= '0;
                end
            end
        end
    end

    always_comb
    begin
        bank_clear = '0;
        if (cfg_we && cfg_index >= REG_COUNT0)
        begin
            bank_clear[cfg_index[BANK_W-1:0]] = 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
        bid_reg <= bid_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== hdl/size_class_buffer_allocator_core.sv =====
// Top level of the size-class buffer allocator: sequencer plus state memories.
// Depends on sba_pkg, sba_if.sv, sba_ctrl and sba_store.
//
//  channel | dir | handshake      | word
//  req     | in  | valid / ready  | operation, bank_sel, buffer_index, owner_tag, wanted_size
//  rsp     | out | valid / ready  | status, granted_bank, granted_buffer, in_use_count
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// Query and zero-tag requests are answered from the idle state; a release reads the
// owner, then writes back; an allocation reads the ring slot, then the owner of its
// id, then writes back, and allocate by size reads again for each bank passed over.
// A request is taken only in the idle state. After reset a clearing pass rewrites
// all banks; a count write clears its bank. Requests are held off while any clearing
// is pending. A waiting result holds the next request off until it is taken.
module size_class_buffer_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    sba_req_if.sink                        req,
    sba_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sba_pkg::*;

    mem_cmd_t             cmd;
    logic [NUM_BANKS-1:0] bank_clear;
    logic                 clr_busy;
    logic [RING_W-1:0]    ring_rdata;
    logic [TAG_W-1:0]     own_rdata;

    sba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .bank_clear(bank_clear), .clr_busy(clr_busy),
        .ring_rdata(ring_rdata), .own_rdata(own_rdata)
    );

    sba_store u_store (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .bank_clear(bank_clear),
        .clr_busy(clr_busy), .ring_rdata(ring_rdata), .own_rdata(own_rdata)
    );

endmodule

// ===== hdl/sba_checker.sv =====
// Port-level checks for the allocator core, bound to the top level.
// Depends on sba_pkg and sba_if.sv.
module sba_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input sba_pkg::rsp_t rsp_data
);
    import sba_pkg::*;

    // A failed request never names a granted buffer.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_buffer == '0
        && rsp_data.granted_bank == '0)
        else $error("failed word carries a grant");

    // No new request is taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted under a pending result");

    // A taken result is not offered again in the next cycle.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("result offered twice");

    // A stalled result holds its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

endmodule

bind size_class_buffer_allocator_core sba_checker u_sba_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== sim/size_class_buffer_allocator_core_tb.sv =====
// Testbench for size_class_buffer_allocator_core: directed table, then random requests.
// Depends on sba_pkg, sba_if.sv and the allocator RTL; checks results against its own predictor.
`timescale 1ns / 100ps

module size_class_buffer_allocator_core_tb;
    import sba_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t               kind;
        req_t                    word;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   value;
        bit                      typed;
        rsp_t                    want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sba_req_if req_ch ();
    sba_rsp_if rsp_ch ();

    size_class_buffer_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [RING_W-1:0] ring_m  [NUM_BANKS][BUFFERS_PER_BANK];
    logic [TAG_W-1:0]  owner_m [NUM_BANKS][BUFFERS_PER_BANK];
    logic [ID_W-1:0]   acur_m  [NUM_BANKS];
    logic [ID_W-1:0]   rcur_m  [NUM_BANKS];
    logic [CNT_W-1:0]  used_m  [NUM_BANKS];
    logic [SIZE_W-1:0] size_m  [NUM_BANKS];
    logic [CNT_W-1:0]  count_m [NUM_BANKS];

    rsp_t expected_rsp [$];
    int   mismatches;
    bit   hold_req;
    bit   calm;
    dir_row_t dir_tab [$];

    // Clock.
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Generous overall limit.
    initial
    begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int ring_len(int b);
        int c;
        c = count_m[b];
        if (c == 0) c = 1;
        if (c > BUFFERS_PER_BANK) c = BUFFERS_PER_BANK;
        return c;
    endfunction

    function automatic logic [ID_W-1:0] step_cursor(logic [ID_W-1:0] cur, int b);
        int n;
        n = int'(cur) + 1;
        if (n >= ring_len(b)) n = 0;
        return n[ID_W-1:0];
    endfunction

    function automatic void bank_clear(int b);
        for (int i = 0; i < BUFFERS_PER_BANK; i++)
        begin
            ring_m[b][i]  = {1'b1, i[ID_W-1:0]};
            owner_m[b][i] = '0;
        end
        acur_m[b] = '0;
        rcur_m[b] = '0;
        used_m[b] = '0;
    endfunction

    function automatic void model_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        int b;
        b = idx % NUM_BANKS;
        if (idx >= REG_COUNT0)
        begin
            count_m[b] = v[CNT_W-1:0];
            bank_clear(b);
        end
        else
            size_m[b] = v;
    endfunction

    // Takes the id under the allocate cursor of bank b for the given tag.
    function automatic logic [1:0] take_buffer(int b, logic [TAG_W-1:0] tag,
                                               output logic [ID_W-1:0] id);
        logic [RING_W-1:0] e;
        logic [ID_W-1:0] bid;
        id = '0;
        if (tag == '0) return ST_NO_FREE;
        e = ring_m[b][acur_m[b]];
        if (!e[RING_W-1]) return ST_NO_FREE;
        bid = e[ID_W-1:0];
        if (owner_m[b][bid] != '0) return ST_OWNED;
        owner_m[b][bid] = tag;
        ring_m[b][acur_m[b]] = '0;
        acur_m[b] = step_cursor(acur_m[b], b);
        if (used_m[b] < BUFFERS_PER_BANK) used_m[b]++;
        id = bid;
        return ST_OK;
    endfunction

    function automatic logic [1:0] return_buffer(int b, logic [ID_W-1:0] idx);
        if (owner_m[b][idx] == '0) return ST_UNOWNED;
        owner_m[b][idx] = '0;
        ring_m[b][rcur_m[b]] = {1'b1, idx};
        rcur_m[b] = step_cursor(rcur_m[b], b);
        if (used_m[b] > 0) used_m[b]--;
        return ST_OK;
    endfunction

    // Computes the result word of one request and updates the shadow state.
    function automatic rsp_t predict_grant(req_t r);
        rsp_t o;
        logic [ID_W-1:0] id;
        logic [1:0] st;
        int cb;
        bit owned_seen;
        bit done;
        o = '0;
        cb = r.bank_sel;
        case (r.operation)
            OP_ALLOC:
            begin
                o.status = take_buffer(cb, r.owner_tag, id);
                if (o.status == ST_OK)
                begin
                    o.granted_bank = r.bank_sel;
                    o.granted_buffer = id;
                end
            end
            OP_BY_SIZE:
            begin
                owned_seen = 1'b0;
                done = 1'b0;
                for (int b = 0; b < NUM_BANKS && !done; b++)
                begin
                    if (size_m[b] >= r.wanted_size)
                    begin
                        st = take_buffer(b, r.owner_tag, id);
                        if (st == ST_OK)
                        begin
                            done = 1'b1;
                            o.granted_bank = b[BANK_W-1:0];
                            o.granted_buffer = id;
                            cb = b;
                        end
                        else if (st == ST_OWNED)
                            owned_seen = 1'b1;
                    end
                end
                o.status = done ? ST_OK : (owned_seen ? ST_OWNED : ST_NO_FREE);
            end
            OP_RELEASE:
                o.status = return_buffer(cb, r.buffer_index);
            default:
                o.status = ST_OK;
        endcase
        o.in_use_count = used_m[cb];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one request word and records the expected result at acceptance.
    task automatic send_word(req_t r, bit typed, rsp_t want);
        int g;
        rsp_t p;
        g = pick_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        p = predict_grant(r);
        expected_rsp.push_back(typed ? want : p);
    endtask

    task automatic wait_drained();
        while (expected_rsp.size() != 0) @(posedge clk);
    endtask

    // Register write, only once the block has gone quiet.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_cfg(idx, v);
    endtask

    function automatic dir_row_t rq(logic [1:0] op, int bank, int idx, logic [TAG_W-1:0] tag,
                                    int want_sz, bit typed, rsp_t want);
        dir_row_t d;
        d.kind = ROW_REQ;
        d.word = '{op, bank[BANK_W-1:0], idx[ID_W-1:0], tag, want_sz[SIZE_W-1:0]};
        d.idx = '0;
        d.value = '0;
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    function automatic dir_row_t cf(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        dir_row_t d;
        d.kind = ROW_CFG;
        d.word = '0;
        d.idx = idx;
        d.value = v;
        d.typed = 1'b0;
        d.want = '0;
        return d;
    endfunction

    // Release target: mostly a buffer that is owned right now.
    function automatic logic [ID_W-1:0] pick_release(int b);
        int s;
        s = $urandom_range(0, BUFFERS_PER_BANK - 1);
        if ($urandom_range(0, 9) < 8)
            for (int k = 0; k < BUFFERS_PER_BANK; k++)
                if (owner_m[b][(s + k) % BUFFERS_PER_BANK] != '0)
                    return ID_W'((s + k) % BUFFERS_PER_BANK);
        return s[ID_W-1:0];
    endfunction

    function automatic req_t random_word();
        req_t r;
        int w;
        int b;
        r.bank_sel = BANK_W'($urandom_range(0, NUM_BANKS - 1));
        b = r.bank_sel;
        w = $urandom_range(0, 99);
        r.operation = (w < 35) ? OP_ALLOC : (w < 60) ? OP_BY_SIZE : (w < 90) ? OP_RELEASE
                    : OP_QUERY;
        r.buffer_index = pick_release(b);
        w = $urandom_range(0, 19);
        r.owner_tag = (w == 0) ? '0 : (w == 1) ? '1 : $urandom();
        w = $urandom_range(0, 9);
        case (w)
            0: r.wanted_size = '0;
            1: r.wanted_size = '1;
            2: r.wanted_size = SIZE_W'($urandom());
            3: r.wanted_size = size_m[$urandom_range(0, NUM_BANKS - 1)] + 1'b1;
            default: r.wanted_size = size_m[$urandom_range(0, NUM_BANKS - 1)];
        endcase
        return r;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", rsp_ch.data);
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp_ch.data.status !== e.status
                    || rsp_ch.data.granted_bank !== e.granted_bank
                    || rsp_ch.data.granted_buffer !== e.granted_buffer
                    || rsp_ch.data.in_use_count !== e.in_use_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st %0d bank %0d buf %0d used %0d, ",
                                  "got st %0d bank %0d buf %0d used %0d"},
                                 e.status, e.granted_bank, e.granted_buffer, e.in_use_count,
                                 rsp_ch.data.status, rsp_ch.data.granted_bank,
                                 rsp_ch.data.granted_buffer, rsp_ch.data.in_use_count);
                end
            end
        end
    end

    // Result receiver: random stalls, and a long hold-off on request.
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rsp_t none;
        logic [CNT_W-1:0] cnt;
        logic [SIZE_W-1:0] sz;
        none = '0;
        mismatches = 0;
        hold_req = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        size_m = '{16'd64, 16'd256, 16'd1024, 16'd4096};
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            count_m[b] = 9'd256;
            bank_clear(b);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset values, extremes, zero tag, full bank, error codes.
        dir_tab.push_back(rq(OP_QUERY, 0, 0, 1, 0, 1, '{ST_OK, 0, 0, 0}));
        dir_tab.push_back(rq(OP_ALLOC, 0, 0, '1, 0, 1, '{ST_OK, 0, 0, 1}));
        dir_tab.push_back(rq(OP_ALLOC, 3, 0, 1, 0, 1, '{ST_OK, 3, 0, 1}));
        dir_tab.push_back(rq(OP_ALLOC, 1, 0, 0, 0, 1, '{ST_NO_FREE, 0, 0, 0}));
        dir_tab.push_back(rq(OP_RELEASE, 2, 255, 1, 0, 1, '{ST_UNOWNED, 0, 0, 0}));
        dir_tab.push_back(rq(OP_RELEASE, 0, 0, 1, 0, 1, '{ST_OK, 0, 0, 0}));
        dir_tab.push_back(rq(OP_BY_SIZE, 0, 0, 5, 0, 1, '{ST_OK, 0, 1, 1}));
        dir_tab.push_back(rq(OP_BY_SIZE, 0, 0, 7, 16'hFFFF, 0, none));
        dir_tab.push_back(rq(OP_BY_SIZE, 2, 0, 7, 4096, 0, none));
        dir_tab.push_back(rq(OP_BY_SIZE, 1, 0, 0, 1025, 0, none));
        dir_tab.push_back(rq(OP_QUERY, 3, 0, 1, 0, 0, none));
        // A count of zero acts as a one-buffer bank.
        dir_tab.push_back(cf(REG_COUNT0, 16'hFE00));
        dir_tab.push_back(rq(OP_ALLOC, 0, 0, 3, 0, 1, '{ST_OK, 0, 0, 1}));
        dir_tab.push_back(rq(OP_ALLOC, 0, 0, 4, 0, 1, '{ST_NO_FREE, 0, 0, 1}));
        dir_tab.push_back(rq(OP_BY_SIZE, 0, 0, 9, 0, 0, none));
        dir_tab.push_back(rq(OP_RELEASE, 0, 0, 1, 0, 1, '{ST_OK, 0, 0, 0}));
        dir_tab.push_back(cf(CFG_IDX_W'(REG_SIZE0 + 1), 16'hFFFF));
        dir_tab.push_back(cf(REG_COUNT0, 16'h0100));
        dir_tab.push_back(rq(OP_BY_SIZE, 3, 0, 2, 16'hFFFF, 0, none));
        dir_tab.push_back(rq(OP_QUERY, 1, 0, 1, 0, 0, none));
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].idx, dir_tab[i].value);
            else
                send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases, each under fresh register settings.
        for (int p = 0; p < PHASES; p++)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                sz = (p == 1) ? 16'hFFFF : (p == 2) ? 16'h0000
                   : SIZE_W'($urandom_range(0, 4096) * (b + 1));
                if (p == 3) sz = SIZE_W'($urandom());
                write_reg(CFG_IDX_W'(REG_SIZE0 + b), sz);
                cnt = (p == 1) ? 9'd256 : (p == 2) ? 9'd1
                    : (p == 4) ? 9'h1FF : CNT_W'($urandom_range(0, 12));
                write_reg(CFG_IDX_W'(REG_COUNT0 + b), {7'($urandom()), cnt});
            end
            calm = (p == 5);
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once, the sender waits for every outstanding result.
                if (p == 6 && n == ITEMS_PER_PHASE / 2)
                begin
                    req_ch.valid <= 1'b0;
                    @(posedge clk);
                    wait_drained();
                end
                send_word(random_word(), 1'b0, none);
            end
        end
        calm = 1'b0;

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
